// File: design/tsir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsir_pkg: shared types and codes of the tile slide image remap
// Request and result payloads, configuration codes, controller/datapath
// command and status groups, and the controller state type.
// ----------------------------------------------------------------------------
package tsir_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_WIDTH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_HEIGHT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_HAS_ALPHA    = 3'd6;

  // Request commands
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TILE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Background codes
  localparam logic [1:0] BG_TRANSPARENT = 2'd0;
  localparam logic [1:0] BG_BLACK       = 2'd1;
  localparam logic [1:0] BG_WHITE       = 2'd2;

  localparam logic [31:0] ALPHA_OPAQUE = 32'd255;

  typedef struct packed {
    logic [1:0]        command;
    logic [31:0]       source_pixel;
    logic signed [7:0] tile_dx;
    logic signed [7:0] tile_dy;
  } in_req_t;

  typedef struct packed {
    logic [31:0] result_pixel;
    logic        last_pixel;
  } out_rsp_t;

  // Effective (clamped) configuration seen by the datapath
  typedef struct packed {
    logic [7:0]  fw;
    logic [7:0]  fh;
    logic [7:0]  tw;
    logic [7:0]  th;
    logic [31:0] mask;
    logic [31:0] bg_word;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic read_issue;
    logic tile_start;
    logic base;
    logic copy;
    logic capture;
  } ctrl_cmd_t;

  typedef struct packed {
    logic copy_last;
    logic out_free;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_COPY,
    ST_DRAIN,
    ST_READ
  } state_t;

  function automatic logic [31:0] chan_mask(input logic [2:0] ch);
    logic [31:0] m;
    case (ch)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// File: design/tsir_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsir_cfg: configuration registers
// Holds the written registers and derives the clamped sizes, channel mask
// and background word.
// ----------------------------------------------------------------------------
module tsir_cfg #(
  parameter int MAX_WIDTH    = 128,
  parameter int MAX_HEIGHT   = 128,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [tsir_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tsir_pkg::CFG_DATA_W-1:0]  cfg_data,
  output tsir_pkg::cfg_t                   cfg
);
  import tsir_pkg::*;

  logic [7:0] frame_width;
  logic [7:0] frame_height;
  logic [7:0] tile_w;
  logic [7:0] tile_h;
  logic [1:0] background;
  logic [2:0] channels;
  logic       has_alpha;

  logic [2:0] eff_ch;
  logic [1:0] alpha_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 8'd128;
      frame_height <= 8'd128;
      tile_w       <= 8'd50;
      tile_h       <= 8'd50;
      background   <= BG_TRANSPARENT;
      channels     <= 3'd4;
      has_alpha    <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_TILE_WIDTH:   tile_w       <= cfg_data;
        REG_TILE_HEIGHT:  tile_h       <= cfg_data;
        REG_BACKGROUND:   background   <= cfg_data[1:0];
        REG_CHANNELS:     channels     <= cfg_data[2:0];
        REG_HAS_ALPHA:    has_alpha    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.fw = (frame_width == 8'd0) ? 8'd1 :
             ((int'(frame_width) > MAX_WIDTH) ? 8'(MAX_WIDTH) : frame_width);
    cfg.fh = (frame_height == 8'd0) ? 8'd1 :
             ((int'(frame_height) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : frame_height);
    cfg.tw = (tile_w == 8'd0) ? 8'd1 : tile_w;
    cfg.th = (tile_h == 8'd0) ? 8'd1 : tile_h;
    eff_ch = (channels == 3'd0) ? 3'd1 :
             ((int'(channels) > MAX_CHANNELS) ? 3'(MAX_CHANNELS) : channels);
    alpha_pos = 2'(eff_ch - 3'd1);
    cfg.mask  = chan_mask(eff_ch);
    // unused background code falls through to transparent
    case (background)
      BG_WHITE: cfg.bg_word = cfg.mask;
      BG_BLACK: cfg.bg_word = has_alpha ? (ALPHA_OPAQUE << {alpha_pos, 3'b000}) : 32'd0;
      default:  cfg.bg_word = 32'd0;
    endcase
  end

endmodule

// File: design/tsir_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsir_ctrl: request sequencer
// Accepts requests in idle and steps the datapath through tile copies and
// result reads.
// ----------------------------------------------------------------------------
module tsir_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           command,
  input  tsir_pkg::dp_status_t status,
  output logic                 in_ready,
  output tsir_pkg::ctrl_cmd_t  cmd
);
  import tsir_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && command == CMD_TILE) begin
          state_next = ST_BASE;
        end else if (in_valid && command == CMD_READ) begin
          state_next = ST_READ;
        end
      end
      ST_BASE:  state_next = ST_COPY;
      ST_COPY:  if (status.copy_last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_IDLE;
      ST_READ:  if (status.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state == ST_IDLE);
    accept         = in_valid && in_ready;
    cmd.load       = accept && command == CMD_LOAD;
    cmd.read_issue = accept && command == CMD_READ;
    cmd.tile_start = accept && command == CMD_TILE;
    cmd.base       = (state == ST_BASE);
    cmd.copy       = (state == ST_COPY);
    cmd.capture    = (state == ST_READ) && status.out_free;
  end

endmodule

// File: design/tsir_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsir_datapath: stores, indexes and tile copy engine
// Source and result memories, load/read indexes, tile position, the copy
// scan counters and the output register.
// ----------------------------------------------------------------------------
module tsir_datapath #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tsir_pkg::cfg_t       cfg,
  input  tsir_pkg::ctrl_cmd_t  cmd,
  input  tsir_pkg::in_req_t    in_req,
  input  logic                 out_ready,
  output logic                 out_valid,
  output tsir_pkg::out_rsp_t   out_rsp,
  output tsir_pkg::dp_status_t status
);
  import tsir_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int ROWW  = $clog2(MAX_HEIGHT);
  localparam int CW    = ((COLW > ROWW) ? COLW : ROWW) + 10;

  logic [31:0] src_mem [DEPTH];
  logic [31:0] res_mem [DEPTH];

  logic [AW:0]   count;
  logic [AW-1:0] load_idx, load_idx0;
  logic [AW-1:0] read_idx, read_idx0;
  logic [AW:0]   load_inc, read_inc;

  logic [COLW-1:0] col;
  logic [ROWW-1:0] row;
  logic [COLW:0]   col_inc;
  logic [ROWW:0]   row_inc;
  logic            col_end, row_end;

  logic signed [CW-1:0] x0, y0, ty_init;
  logic signed [7:0]    dx, dy;
  logic signed [CW-1:0] sx, tx, sy, ty;
  logic signed [CW-1:0] fw_s, fh_s;
  logic [AW-1:0]        src_base, dst_base;
  logic [AW-1:0]        src_addr, dst_addr;
  logic [7:0]           xx, yy;
  logic                 x_last, y_last, pix_ok;

  logic          wr_pend;
  logic [AW-1:0] wr_addr;
  logic [31:0]   src_rdata;
  logic [31:0]   res_rdata;
  logic          last_q;

  // Index bookkeeping: restart an index that a shrinking frame left behind
  assign count     = (AW+1)'(cfg.fw) * (AW+1)'(cfg.fh);
  assign load_idx0 = ({1'b0, load_idx} >= count) ? '0 : load_idx;
  assign read_idx0 = ({1'b0, read_idx} >= count) ? '0 : read_idx;
  assign load_inc  = {1'b0, load_idx0} + (AW+1)'(1);
  assign read_inc  = {1'b0, read_idx0} + (AW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_idx <= '0;
      read_idx <= '0;
    end else begin
      if (cmd.load) load_idx <= (load_inc >= count) ? '0 : load_inc[AW-1:0];
      if (cmd.read_issue) read_idx <= (read_inc >= count) ? '0 : read_inc[AW-1:0];
    end
  end

  // Tile position advances when the tile request is taken
  assign col_inc = {1'b0, col} + (COLW+1)'(1);
  assign row_inc = {1'b0, row} + (ROWW+1)'(1);
  assign col_end = ((COLW+9)'(col_inc) * (COLW+9)'(cfg.tw)) >= (COLW+9)'(cfg.fw);
  assign row_end = ((ROWW+9)'(row_inc) * (ROWW+9)'(cfg.th)) >= (ROWW+9)'(cfg.fh);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cmd.tile_start) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row_inc[ROWW-1:0];
      end else begin
        col <= col_inc[COLW-1:0];
      end
    end
  end

  // Copy scan
  assign fw_s     = CW'(cfg.fw);
  assign fh_s     = CW'(cfg.fh);
  assign ty_init  = y0 + CW'(dy);
  assign x_last   = (xx == cfg.tw - 8'd1);
  assign y_last   = (yy == cfg.th - 8'd1);
  assign pix_ok   = (sy < fh_s) && !ty[CW-1] && (ty < fh_s) &&
                    (sx < fw_s) && !tx[CW-1] && (tx < fw_s);
  assign src_addr = src_base + AW'(sx);
  assign dst_addr = dst_base + AW'(tx);

  always_ff @(posedge clk) begin
    if (cmd.tile_start) begin
      x0 <= CW'(col) * CW'(cfg.tw);
      y0 <= CW'(row) * CW'(cfg.th);
      dx <= in_req.tile_dx;
      dy <= in_req.tile_dy;
    end
    if (cmd.base) begin
      sx       <= x0;
      tx       <= x0 + CW'(dx);
      sy       <= y0;
      ty       <= ty_init;
      src_base <= AW'(AW'(y0) * AW'(cfg.fw));
      dst_base <= AW'(AW'(ty_init) * AW'(cfg.fw));
      xx       <= '0;
      yy       <= '0;
    end else if (cmd.copy) begin
      if (x_last) begin
        // wrap to the next tile row
        xx       <= '0;
        sx       <= x0;
        tx       <= x0 + CW'(dx);
        yy       <= yy + 8'd1;
        sy       <= sy + CW'(1);
        ty       <= ty + CW'(1);
        src_base <= src_base + AW'(cfg.fw);
        dst_base <= dst_base + AW'(cfg.fw);
      end else begin
        xx <= xx + 8'd1;
        sx <= sx + CW'(1);
        tx <= tx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.copy && pix_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.copy) wr_addr <= dst_addr;
  end

  // Source store: written by loads, read by the copy scan
  always_ff @(posedge clk) begin
    if (cmd.load) src_mem[load_idx0] <= in_req.source_pixel & cfg.mask;
    if (cmd.copy && pix_ok) src_rdata <= src_mem[src_addr];
  end

  // Result store: background on load, copied pixel in the cycle after its read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_mem[load_idx0] <= cfg.bg_word;
    end else if (wr_pend) begin
      res_mem[wr_addr] <= src_rdata;
    end
    if (cmd.read_issue) begin
      res_rdata <= res_mem[read_idx0];
      last_q    <= (read_inc == count);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.capture) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_rsp.result_pixel <= res_rdata & cfg.mask;
      out_rsp.last_pixel   <= last_q;
    end
  end

  assign status.copy_last = x_last && y_last;
  assign status.out_free  = !out_valid || out_ready;

endmodule

// File: design/tile_slide_image_remap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_slide_image_remap: tiled image shift onto a background frame
// Loads a frame, copies it tile by tile with per-tile offsets into a
// background-filled result store, and streams the result back out.
// ----------------------------------------------------------------------------
// Loads leave the block idle, so loads stream at one per cycle. A read request
// first does the registered result-store read and then, once the output
// register is free, moves the word into it; the output register then holds
// the pixel until the consumer takes it while the next request is already
// accepted. A tile request takes the request and advances the tile position,
// forms the row base addresses, reads each tile pixel through the single
// source-store read port, and finishes the last result-store write. Both
// stores are plain memories with no reset or clearing pass; reading a pixel
// that was never loaded gives an unspecified value. Write configuration only
// while the block is idle.
// ----------------------------------------------------------------------------
module tile_slide_image_remap #(
  parameter int MAX_WIDTH    = 128,
  parameter int MAX_HEIGHT   = 128,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [tsir_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tsir_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tsir_pkg::in_req_t                in_req,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tsir_pkg::out_rsp_t               out_rsp
);
  import tsir_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  ctrl_cmd;
  dp_status_t status;

  // Clamped sizes, channel mask and background word
  tsir_cfg #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer: hold off new requests during tile copies and pending reads
  tsir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (in_req.command),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (ctrl_cmd)
  );

  // Memories, indexes, copy scan and output register
  tsir_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (ctrl_cmd),
    .in_req    (in_req),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .status    (status)
  );

  // At most one datapath operation per cycle; loads never race copy writes
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl_cmd.load, ctrl_cmd.read_issue, ctrl_cmd.tile_start,
              ctrl_cmd.base, ctrl_cmd.copy, ctrl_cmd.capture}))
    else $error("more than one datapath operation in one cycle");

  // A taken tile request goes straight to base address setup
  a_tile_to_base: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_req.command == CMD_TILE |=> ctrl_cmd.base)
    else $error("tile request did not start base setup");

  // The last scan pixel is followed by a drain cycle with requests held off
  a_copy_drain: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.copy && status.copy_last |=> !ctrl_cmd.copy && !in_ready)
    else $error("copy scan did not drain its last write");

endmodule

// File: dv/tile_slide_image_remap_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_slide_image_remap_test: regression for the tile slide image remap
// Loads frames, slides their tiles by signed offsets and reads the result
// back. A behavioral copy of the block's stores predicts every result
// pixel, and each one is checked as it leaves the block.
// ----------------------------------------------------------------------------
module tile_slide_image_remap_test;
  import tsir_pkg::*;

  localparam int FRAME_MAX_W  = 128;
  localparam int FRAME_MAX_H  = 128;
  localparam int CHANNEL_MAX  = 4;
  localparam int STORE_WORDS  = FRAME_MAX_W * FRAME_MAX_H;
  localparam int QUIET_LIMIT  = 300000;  // well above one 255x255 tile pass
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 200;
  localparam int MAX_REPORTS  = 10;

  // Codes with no name in the package: the spare command and register index
  localparam logic [1:0]             CMD_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_req_t                in_req = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_rsp_t               out_rsp;

  tile_slide_image_remap u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioral copy of the block: registers, stores and positions
  // --------------------------------------------------------------------------
  logic [7:0]  cfg_fw = 8'd128;
  logic [7:0]  cfg_fh = 8'd128;
  logic [7:0]  cfg_tw = 8'd50;
  logic [7:0]  cfg_th = 8'd50;
  logic [1:0]  cfg_bg = BG_TRANSPARENT;
  logic [2:0]  cfg_ch = 3'd4;
  logic        cfg_alpha = 1'b1;

  logic [31:0] src_mem [STORE_WORDS];
  logic [31:0] res_mem [STORE_WORDS];
  bit          src_written [STORE_WORDS];
  bit          res_written [STORE_WORDS];
  int          load_pos = 0;
  int          read_pos = 0;
  int          tile_col = 0;
  int          tile_row = 0;

  out_rsp_t    pending_pixels [$];
  int          tile_busy_cycles = 0;
  int          sent_items = 0;
  int          mismatch_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;

  function automatic int eff_fw();
    return (cfg_fw < 1) ? 1 : ((cfg_fw > FRAME_MAX_W) ? FRAME_MAX_W : int'(cfg_fw));
  endfunction

  function automatic int eff_fh();
    return (cfg_fh < 1) ? 1 : ((cfg_fh > FRAME_MAX_H) ? FRAME_MAX_H : int'(cfg_fh));
  endfunction

  function automatic int eff_tw();
    return (cfg_tw < 1) ? 1 : int'(cfg_tw);
  endfunction

  function automatic int eff_th();
    return (cfg_th < 1) ? 1 : int'(cfg_th);
  endfunction

  function automatic int eff_ch();
    return (cfg_ch < 1) ? 1 : ((cfg_ch > CHANNEL_MAX) ? CHANNEL_MAX : int'(cfg_ch));
  endfunction

  function automatic logic [31:0] pixel_mask();
    int ch;
    ch = eff_ch();
    if (ch >= 4) return 32'hFFFF_FFFF;
    return (32'd1 << (8 * ch)) - 32'd1;
  endfunction

  // Fill color written at each loaded position; black only carries an
  // opaque alpha byte when the last channel is alpha.
  function automatic logic [31:0] fill_word();
    if (cfg_bg == BG_WHITE) return pixel_mask();
    if (cfg_bg == BG_BLACK && cfg_alpha) return ALPHA_OPAQUE << (8 * (eff_ch() - 1));
    return 32'd0;
  endfunction

  // True when every in-frame source pixel of the next tile has been loaded
  function automatic bit tile_sources_loaded();
    int fw, fh, tw, th, x0, y0, sx, sy;
    fw = eff_fw();
    fh = eff_fh();
    tw = eff_tw();
    th = eff_th();
    x0 = tile_col * tw;
    y0 = tile_row * th;
    for (int yy = 0; yy < th; yy++) begin
      sy = y0 + yy;
      if (sy >= fh) break;
      for (int xx = 0; xx < tw; xx++) begin
        sx = x0 + xx;
        if (sx >= fw) break;
        if (!src_written[sy * fw + sx]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit read_pixel_loaded();
    int idx;
    idx = (read_pos >= eff_fw() * eff_fh()) ? 0 : read_pos;
    return res_written[idx];
  endfunction

  task automatic apply_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
    case (idx)
      REG_FRAME_WIDTH:  cfg_fw = data;
      REG_FRAME_HEIGHT: cfg_fh = data;
      REG_TILE_WIDTH:   cfg_tw = data;
      REG_TILE_HEIGHT:  cfg_th = data;
      REG_BACKGROUND:   cfg_bg = data[1:0];
      REG_CHANNELS:     cfg_ch = data[2:0];
      REG_HAS_ALPHA:    cfg_alpha = data[0];
      default: ;
    endcase
  endtask

  // Copy the next tile into the result store, then advance the tile position
  task automatic slide_tile(input logic signed [7:0] dx, input logic signed [7:0] dy);
    int fw, fh, tw, th, x0, y0, sx, sy, tx, ty, ox, oy;
    fw = eff_fw();
    fh = eff_fh();
    tw = eff_tw();
    th = eff_th();
    ox = dx;
    oy = dy;
    x0 = tile_col * tw;
    y0 = tile_row * th;
    for (int yy = 0; yy < th; yy++) begin
      sy = y0 + yy;
      ty = sy + oy;
      if (sy >= fh || ty < 0 || ty >= fh) continue;
      for (int xx = 0; xx < tw; xx++) begin
        sx = x0 + xx;
        tx = sx + ox;
        if (sx >= fw || tx < 0 || tx >= fw) continue;
        res_mem[ty * fw + tx] = src_mem[sy * fw + sx];
        res_written[ty * fw + tx] = src_written[sy * fw + sx];
      end
    end
    tile_col++;
    if (tile_col * tw >= fw) begin
      tile_col = 0;
      tile_row++;
      if (tile_row * th >= fh) tile_row = 0;
    end
    tile_busy_cycles = tw * th + 3;
  endtask

  // Update the copy for one accepted request and queue any result it causes
  task automatic remap_request(input in_req_t r);
    int count;
    out_rsp_t rsp;
    count = eff_fw() * eff_fh();
    case (r.command)
      CMD_LOAD: begin
        if (load_pos >= count) load_pos = 0;
        src_mem[load_pos] = r.source_pixel & pixel_mask();
        res_mem[load_pos] = fill_word();
        src_written[load_pos] = 1'b1;
        res_written[load_pos] = 1'b1;
        load_pos++;
        if (load_pos >= count) load_pos = 0;
      end
      CMD_TILE: slide_tile(r.tile_dx, r.tile_dy);
      CMD_READ: begin
        if (read_pos >= count) read_pos = 0;
        rsp.result_pixel = res_mem[read_pos] & pixel_mask();
        rsp.last_pixel = (read_pos == count - 1);
        pending_pixels.push_back(rsp);
        read_pos++;
        if (read_pos >= count) read_pos = 0;
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // phase 0: no idling; 1: sender idles; 2: receiver stalls; 3: both, lightly
  task automatic set_pressure(input int phase);
    case (phase)
      1:       begin idle_pct = 69; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 69; end
      3:       begin idle_pct = 18; stall_pct = 18; end
      default: begin idle_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // Send one request: idle for a random gap, raise valid, hold until taken
  task automatic send_request(input in_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    remap_request(r);
    if (r.command != CMD_UNUSED) sent_items++;
  endtask

  // Turn reads and tiles that would touch never-loaded pixels into loads
  task automatic issue(input logic [1:0] cmd, input logic [31:0] pix,
                       input logic [7:0] dx, input logic [7:0] dy);
    in_req_t r;
    r.command = cmd;
    r.source_pixel = pix;
    r.tile_dx = dx;
    r.tile_dy = dy;
    if (cmd == CMD_READ && !read_pixel_loaded()) r.command = CMD_LOAD;
    if (cmd == CMD_TILE && !tile_sources_loaded()) r.command = CMD_LOAD;
    send_request(r);
  endtask

  // Drop valid, wait for every expected pixel, then let a tile pass finish
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (tile_busy_cycles + DRAIN_CYCLES) @(posedge clk);
    tile_busy_cycles = 0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_register(idx, data);
  endtask

  task automatic set_frame(input logic [7:0] fw, input logic [7:0] fh,
                           input logic [7:0] tw, input logic [7:0] th,
                           input logic [7:0] bg, input logic [7:0] ch,
                           input logic [7:0] alpha, input bit stray);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_TILE_WIDTH, tw);
    write_reg(REG_TILE_HEIGHT, th);
    write_reg(REG_BACKGROUND, bg);
    write_reg(REG_CHANNELS, ch);
    write_reg(REG_HAS_ALPHA, alpha);
    if (stray) write_reg(REG_UNUSED, 8'($urandom_range(255)));
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [7:0] pick_offset(input int span);
    int v;
    if ($urandom_range(99) < 30) return 8'($urandom_range(255));
    v = $urandom_range(2 * span) - span;
    return v[7:0];
  endfunction

  // One well-formed pass: load the whole frame, slide some tiles, read it out
  task automatic run_frame(input int tiles);
    int count, span;
    count = eff_fw() * eff_fh();
    span = (eff_fw() > eff_fh()) ? eff_fw() : eff_fh();
    for (int i = 0; i < count; i++) begin
      issue(CMD_LOAD, $urandom, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
    for (int i = 0; i < tiles; i++) begin
      issue(CMD_TILE, $urandom, pick_offset(span), pick_offset(span));
    end
    for (int i = 0; i < count; i++) begin
      issue(CMD_READ, $urandom, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_corner_cases();
    set_pressure(0);
    // 2x2 frame of 1x1 tiles, white fill, extreme pixel values
    set_frame(8'd2, 8'd2, 8'd1, 8'd1, BG_WHITE, 8'd4, 8'd1, 1'b0);
    issue(CMD_LOAD, 32'h0000_0000, 8'h00, 8'h00);
    issue(CMD_LOAD, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    issue(CMD_LOAD, 32'hA5A5_5A5A, 8'h80, 8'h7F);
    issue(CMD_LOAD, 32'h8000_0001, 8'h7F, 8'h80);
    // first tile pushed off the frame entirely, then real shifts; the fourth
    // tile ends the sequence and wraps the position to the first tile
    issue(CMD_TILE, 32'hFFFF_FFFF, 8'h80, 8'h7F);
    issue(CMD_TILE, 32'h0, 8'h01, 8'h00);
    issue(CMD_TILE, 32'h0, 8'h00, 8'h01);
    issue(CMD_TILE, 32'h0, 8'hFF, 8'hFF);
    issue(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    // five reads: the last pixel is flagged, then the index wraps
    for (int i = 0; i < 5; i++) issue(CMD_READ, 32'hFFFF_FFFF, 8'hFF, 8'hFF);

    // zero sizes act as one, channels 0 as one, background 3 as transparent;
    // the shrink also puts the read index beyond the frame
    set_frame(8'd0, 8'd0, 8'd0, 8'd0, 8'd3, 8'd0, 8'd0, 1'b0);
    issue(CMD_LOAD, 32'hFFFF_FFFF, 8'h00, 8'h00);
    issue(CMD_READ, 32'h0, 8'h00, 8'h00);
    issue(CMD_TILE, 32'h0, 8'h00, 8'h00);
    issue(CMD_READ, 32'h0, 8'h00, 8'h00);

    // black with alpha, channel count above the limit
    set_frame(8'd1, 8'd1, 8'd1, 8'd1, BG_BLACK, 8'd7, 8'd1, 1'b0);
    issue(CMD_LOAD, 32'h1234_5678, 8'h00, 8'h00);
    issue(CMD_READ, 32'h0, 8'h00, 8'h00);

    // black without alpha on three channels drops the top source byte
    set_frame(8'd1, 8'd1, 8'd1, 8'd1, BG_BLACK, 8'd3, 8'd0, 1'b0);
    issue(CMD_LOAD, 32'hFFFF_FFFF, 8'h00, 8'h00);
    issue(CMD_READ, 32'h0, 8'h00, 8'h00);
    issue(CMD_TILE, 32'h0, 8'h00, 8'h00);
    issue(CMD_READ, 32'h0, 8'h00, 8'h00);
  endtask

  task automatic test_size_extremes();
    // tallest frame, width clamped up from zero
    set_pressure($urandom_range(3));
    set_frame(8'd0, 8'd255, 8'd0, 8'd128, BG_BLACK, 8'd3, 8'd1, 1'b0);
    run_frame(3);
    // width clamped down from 255, tiles wider and taller than any frame
    set_pressure($urandom_range(3));
    set_frame(8'd255, 8'd0, 8'd255, 8'd255, BG_TRANSPARENT, 8'd2, 8'd0, 1'b0);
    run_frame(1);
  endtask

  task automatic test_random_remap();
    int first, scene, fw, fh, tw, th, pick, tiles, steps;
    logic [7:0] bg, ch, alpha;
    first = sent_items;
    scene = 0;
    while (sent_items - first < RANDOM_ITEMS || scene < 4) begin
      set_pressure(scene % 4);
      fw = $urandom_range(1, 12);
      fh = $urandom_range(1, 10);
      pick = $urandom_range(99);
      if (pick < 5) fw = 0;
      else if (pick < 10) fh = 0;
      else if (pick < 15) begin fw = $urandom_range(129, 255); fh = $urandom_range(0, 2); end
      else if (pick < 20) begin fh = $urandom_range(129, 255); fw = $urandom_range(0, 2); end
      pick = $urandom_range(99);
      tw = (pick < 8) ? 0 : ((pick < 16) ? $urandom_range(13, 40) : $urandom_range(1, 6));
      pick = $urandom_range(99);
      th = (pick < 8) ? 0 : ((pick < 16) ? $urandom_range(13, 40) : $urandom_range(1, 6));
      bg = 8'($urandom_range(3));
      ch = 8'($urandom_range(7));
      alpha = 8'($urandom_range(1));
      // now and then set the register bits above the used width
      if ($urandom_range(3) == 0) begin
        bg[7:2] = 6'($urandom_range(63));
        ch[7:3] = 5'($urandom_range(31));
        alpha[7:1] = 7'($urandom_range(127));
      end
      set_frame(8'(fw), 8'(fh), 8'(tw), 8'(th), bg, ch, alpha, $urandom_range(7) == 0);
      if ($urandom_range(99) < 80) begin
        tiles = ((eff_fw() + eff_tw() - 1) / eff_tw()) * ((eff_fh() + eff_th() - 1) / eff_th());
        tiles = $urandom_range(1, (tiles + 2 > 30) ? 30 : tiles + 2);
        run_frame(tiles);
        // extra reads run across the frame end and wrap
        if ($urandom_range(3) == 0) begin
          steps = $urandom_range(1, 4);
          for (int i = 0; i < steps; i++) issue(CMD_READ, $urandom, 8'h00, 8'h00);
        end
      end else begin
        // noise: an unordered mix of all commands, partial loads included
        steps = $urandom_range(15, 40);
        for (int i = 0; i < steps; i++) begin
          issue(2'($urandom_range(3)), $urandom, 8'($urandom_range(255)),
                8'($urandom_range(255)));
        end
      end
      scene++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall at random according to the current phase
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check each taken result against the oldest expected pixel
  always @(posedge clk) begin
    out_rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result pixel %h last %b",
                   $realtime, out_rsp.result_pixel, out_rsp.last_pixel);
      end else begin
        want = pending_pixels.pop_front();
        if (out_rsp.result_pixel !== want.result_pixel ||
            out_rsp.last_pixel !== want.last_pixel) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: expected pixel %h last %b, got pixel %h last %b",
                     $realtime, want.result_pixel, want.last_pixel,
                     out_rsp.result_pixel, out_rsp.last_pixel);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tile_slide_image_remap regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_corner_cases();
    test_size_extremes();
    test_random_remap();
    wait_idle();
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("tile_slide_image_remap regression: pass");
    end else begin
      $display("tile_slide_image_remap regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
design/tsir_pkg.sv
design/tsir_cfg.sv
design/tsir_ctrl.sv
design/tsir_datapath.sv
design/tile_slide_image_remap.sv
dv/tile_slide_image_remap_test.sv
